@@ rtl/gpm_pkg.sv @@
// gpm_pkg: shared types, command and mode codes for the gpio pin manager
package gpm_pkg;

    localparam int NUM_PORTS_DEF  = 4;
    localparam int PORT_WIDTH_DEF = 16;
    localparam int NUM_MASKS      = 5;
    localparam int OUT_W          = 16;

    localparam int MSK_OUT_CLAIMED = 0;
    localparam int MSK_IN_CLAIMED  = 1;
    localparam int MSK_LAST_SAMPLE = 2;
    localparam int MSK_CHANGE      = 3;
    localparam int MSK_LEVEL       = 4;

    localparam logic [2:0] CMD_REGISTER = 3'd0;
    localparam logic [2:0] CMD_DELETE   = 3'd1;
    localparam logic [2:0] CMD_WRITE    = 3'd2;
    localparam logic [2:0] CMD_READ     = 3'd3;
    localparam logic [2:0] CMD_POLL     = 3'd4;
    localparam logic [2:0] CMD_SAMPLE   = 3'd5;

    localparam logic [2:0] MODE_NONE      = 3'd0;
    localparam logic [2:0] MODE_OUTPUT_PP = 3'd1;
    localparam logic [2:0] MODE_PULLDOWN  = 3'd2;
    localparam logic [2:0] MODE_PULLUP    = 3'd3;
    localparam logic [2:0] MODE_FLOAT     = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [5:0]  pin;
        logic        npn;
        logic        is_output;
        logic        value;
        logic [1:0]  port;
        logic [15:0] port_levels;
    } item_t;

    typedef struct packed {
        logic        status;
        logic        read_value;
        logic        changed;
        logic [2:0]  pin_mode;
        logic [1:0]  drive_port;
        logic [15:0] drive_set;
        logic [15:0] drive_reset;
    } result_t;

endpackage

@@ rtl/gpm_mem.sv @@
// gpm_mem: per-port mask memory with registered read and reset valid bits
module gpm_mem #(
    parameter int NUM_PORTS  = 4,
    parameter int PORT_WIDTH = 16,
    parameter int ADDR_W     = 2
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  rd_en,
    input  logic [ADDR_W-1:0]                     rd_addr,
    output logic [gpm_pkg::NUM_MASKS*PORT_WIDTH-1:0] rd_data,
    input  logic                                  wr_en,
    input  logic [ADDR_W-1:0]                     wr_addr,
    input  logic [gpm_pkg::NUM_MASKS*PORT_WIDTH-1:0] wr_data
);
    import gpm_pkg::*;

    localparam int WORD_W = NUM_MASKS * PORT_WIDTH;

    logic [WORD_W-1:0]    mem [NUM_PORTS];
    logic [NUM_PORTS-1:0] valid_reg;
    logic [WORD_W-1:0]    rd_q_reg;
    logic                 rd_hit_reg;
    logic                 rd_in_range;
    logic                 wr_in_range;

    assign rd_in_range = 32'(rd_addr) < NUM_PORTS;
    assign wr_in_range = 32'(wr_addr) < NUM_PORTS;

    always_ff @(posedge aclk) begin
        if (wr_en && wr_in_range) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr_en && wr_in_range) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= rd_in_range ? valid_reg[rd_addr] : 1'b0;
            end
        end
    end

    // an entry never written reads as its reset value
    assign rd_data = rd_hit_reg ? rd_q_reg : '0;

endmodule

@@ rtl/gpm_exec.sv @@
// gpm_exec: read-modify-write logic for one port word and result formation
module gpm_exec #(
    parameter int NUM_PORTS  = 4,
    parameter int PORT_WIDTH = 16
) (
    input  gpm_pkg::item_t                           item,
    input  logic [gpm_pkg::NUM_MASKS*PORT_WIDTH-1:0] cur_word,
    output logic [gpm_pkg::NUM_MASKS*PORT_WIDTH-1:0] new_word,
    output logic                                     word_we,
    output gpm_pkg::result_t                         result
);
    import gpm_pkg::*;

    localparam int PW = PORT_WIDTH;

    logic [PW-1:0] oc, ic, ls, cp, pl;
    logic [PW-1:0] oc_n, ic_n, ls_n, cp_n, pl_n;
    logic [PW-1:0] pin_m;
    logic [PW-1:0] lev, in_m, smp, diff, agree, flip, smp_ls, smp_pl, out_m;
    logic [1:0]    pin_port;
    logic [3:0]    bit_idx;
    logic          pin_ok;
    logic          port_ok;

    assign oc = cur_word[MSK_OUT_CLAIMED*PW +: PW];
    assign ic = cur_word[MSK_IN_CLAIMED*PW +: PW];
    assign ls = cur_word[MSK_LAST_SAMPLE*PW +: PW];
    assign cp = cur_word[MSK_CHANGE*PW +: PW];
    assign pl = cur_word[MSK_LEVEL*PW +: PW];

    assign pin_port = item.pin[5:4];
    assign bit_idx  = item.pin[3:0];
    assign pin_m    = (32'(bit_idx) < PW) ? (PW'(1) << bit_idx) : '0;
    assign pin_ok   = 32'(pin_port) < NUM_PORTS;
    assign port_ok  = 32'(item.port) < NUM_PORTS;

    // debounce: a level is taken only when two successive samples agree
    assign lev    = PW'(item.port_levels);
    assign in_m   = ic & ~oc;
    assign smp    = lev & in_m;
    assign diff   = (ls ^ smp) & in_m;
    assign smp_ls = (ls & ~diff) | (smp & diff);
    assign agree  = in_m & ~diff;
    assign flip   = (pl ^ smp) & agree;
    assign smp_pl = pl ^ flip;
    assign out_m  = oc & ~ic;

    always_comb begin
        oc_n    = oc;
        ic_n    = ic;
        ls_n    = ls;
        cp_n    = cp;
        pl_n    = pl;
        word_we = 1'b0;
        result  = '0;
        unique case (item.cmd)
            CMD_SAMPLE: begin
                result.drive_port = item.port;
                if (port_ok) begin
                    word_we            = 1'b1;
                    ls_n               = smp_ls;
                    pl_n               = smp_pl;
                    cp_n               = cp | flip;
                    result.drive_set   = OUT_W'(smp_pl & out_m);
                    result.drive_reset = OUT_W'(~smp_pl & out_m);
                end
            end
            CMD_REGISTER, CMD_DELETE, CMD_WRITE, CMD_READ, CMD_POLL: begin
                result.drive_port = pin_port;
                if (!pin_ok) begin
                    result.status = (item.cmd == CMD_REGISTER);
                end else begin
                    word_we = 1'b1;
                    unique case (item.cmd)
                        CMD_REGISTER: begin
                            if (|((ic | oc) & pin_m)) begin
                                result.status = 1'b1;
                            end else begin
                                cp_n = cp & ~pin_m;
                                if (item.is_output) begin
                                    oc_n            = oc | pin_m;
                                    result.pin_mode = MODE_OUTPUT_PP;
                                    if (item.npn) begin
                                        pl_n             = pl | pin_m;
                                        result.drive_set = OUT_W'(pin_m);
                                    end else begin
                                        pl_n               = pl & ~pin_m;
                                        result.drive_reset = OUT_W'(pin_m);
                                    end
                                end else begin
                                    ic_n = ic | pin_m;
                                    if (item.npn) begin
                                        result.pin_mode = MODE_PULLUP;
                                        ls_n            = ls | pin_m;
                                        pl_n            = pl | pin_m;
                                    end else begin
                                        result.pin_mode = MODE_PULLDOWN;
                                        ls_n            = ls & ~pin_m;
                                        pl_n            = pl & ~pin_m;
                                    end
                                end
                            end
                        end
                        CMD_DELETE: begin
                            oc_n            = oc & ~pin_m;
                            ic_n            = ic & ~pin_m;
                            result.pin_mode = MODE_FLOAT;
                        end
                        CMD_WRITE: begin
                            cp_n = cp & ~pin_m;
                            pl_n = (item.value ^ item.npn) ? (pl | pin_m) : (pl & ~pin_m);
                        end
                        CMD_READ: begin
                            cp_n              = cp & ~pin_m;
                            result.read_value = (|(pl & pin_m)) ^ item.npn;
                        end
                        default: begin
                            result.changed = |(cp & pin_m);
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        new_word = '0;
        new_word[MSK_OUT_CLAIMED*PW +: PW] = oc_n;
        new_word[MSK_IN_CLAIMED*PW +: PW]  = ic_n;
        new_word[MSK_LAST_SAMPLE*PW +: PW] = ls_n;
        new_word[MSK_CHANGE*PW +: PW]      = cp_n;
        new_word[MSK_LEVEL*PW +: PW]       = pl_n;
    end

endmodule

@@ rtl/gpio_pin_manager_debounce.sv @@
// gpio_pin_manager_debounce: top level, sequencer, output register and checks
//
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    cmd pin npn is_output value port port_levels
//  m_       out  m_valid/m_ready    status read_value changed pin_mode drive_*
//
// each item first reads its port word from the memory (registered read),
// then does modify, write back and load of the result register
// reset clears the per-port valid bits, no clearing pass
// a new item is taken while a result waits in the output register
// a finished item waits in the execute step while the output register is full and m_ready is low
module gpio_pin_manager_debounce #(
    parameter int NUM_PORTS  = gpm_pkg::NUM_PORTS_DEF,
    parameter int PORT_WIDTH = gpm_pkg::PORT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [5:0]  s_pin,
    input  logic        s_npn,
    input  logic        s_is_output,
    input  logic        s_value,
    input  logic [1:0]  s_port,
    input  logic [15:0] s_port_levels,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic        m_read_value,
    output logic        m_changed,
    output logic [2:0]  m_pin_mode,
    output logic [1:0]  m_drive_port,
    output logic [15:0] m_drive_set,
    output logic [15:0] m_drive_reset
);
    import gpm_pkg::*;

    localparam int ADDR_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int WORD_W = NUM_MASKS * PORT_WIDTH;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t            state_reg;
    logic              m_valid_reg;
    result_t           res_reg;
    item_t             item_reg;
    item_t             in_item;
    result_t           exec_res;
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] wr_word;
    logic              exec_we;
    logic              s_fire;
    logic              retire;
    logic [1:0]        in_sel_port;
    logic [1:0]        cur_sel_port;

    assign in_item = '{cmd: s_cmd, pin: s_pin, npn: s_npn, is_output: s_is_output,
                       value: s_value, port: s_port, port_levels: s_port_levels};

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign retire  = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    assign in_sel_port  = (s_cmd == CMD_SAMPLE) ? s_port : s_pin[5:4];
    assign cur_sel_port = (item_reg.cmd == CMD_SAMPLE) ? item_reg.port : item_reg.pin[5:4];

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= in_item;
        end
    end

    gpm_mem #(
        .NUM_PORTS (NUM_PORTS),
        .PORT_WIDTH(PORT_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_mem (
        .aclk   (aclk),
        .aresetn(aresetn),
        .rd_en  (s_fire),
        .rd_addr(ADDR_W'(in_sel_port)),
        .rd_data(rd_word),
        .wr_en  (retire && exec_we),
        .wr_addr(ADDR_W'(cur_sel_port)),
        .wr_data(wr_word)
    );

    gpm_exec #(
        .NUM_PORTS (NUM_PORTS),
        .PORT_WIDTH(PORT_WIDTH)
    ) u_exec (
        .item    (item_reg),
        .cur_word(rd_word),
        .new_word(wr_word),
        .word_we (exec_we),
        .result  (exec_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (retire) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (retire) begin
                m_valid_reg <= 1'b1;
                res_reg     <= exec_res;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = res_reg.status;
    assign m_read_value  = res_reg.read_value;
    assign m_changed     = res_reg.changed;
    assign m_pin_mode    = res_reg.pin_mode;
    assign m_drive_port  = res_reg.drive_port;
    assign m_drive_set   = res_reg.drive_set;
    assign m_drive_reset = res_reg.drive_reset;

    // one item in flight: accept closes the input until the write-back
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while another is executing");

    // a new result appears only at the retire of an executing item
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_EXEC))
        else $error("result produced without an executing item");

    // a rejected claim never reports a pin mode or drives pins
    a_reject_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_pin_mode == MODE_NONE && m_drive_set == '0
                                && m_drive_reset == '0)
        else $error("rejected item carries mode or drive");

    // the memory is written only while the output register can take the result
    a_write_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        retire |=> m_valid)
        else $error("write-back without result load");

endmodule

@@ tb/sv/gpm_checker.sv @@
`timescale 1ns / 1ps
// gpm_checker: pin bank model and result comparison for the gpio pin manager
module gpm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [5:0]  s_pin,
    input  logic        s_npn,
    input  logic        s_is_output,
    input  logic        s_value,
    input  logic [1:0]  s_port,
    input  logic [15:0] s_port_levels,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_status,
    input  logic        m_read_value,
    input  logic        m_changed,
    input  logic [2:0]  m_pin_mode,
    input  logic [1:0]  m_drive_port,
    input  logic [15:0] m_drive_set,
    input  logic [15:0] m_drive_reset,
    output int          errors,
    output int          pending
);
    import gpm_pkg::*;

    localparam int NP = NUM_PORTS_DEF;

    logic [15:0] out_claim [NP];
    logic [15:0] in_claim  [NP];
    logic [15:0] prev_raw  [NP];
    logic [15:0] chg_flag  [NP];
    logic [15:0] lvl       [NP];

    result_t due_results [$];
    int      fails = 0;

    function automatic result_t gpio_step(item_t it);
        result_t     r;
        logic [1:0]  p;
        logic [15:0] m;
        logic [15:0] sel;
        logic [15:0] s;
        logic [15:0] diff;
        logic [15:0] flip;
        r = '0;
        if (it.cmd == CMD_SAMPLE) begin
            p = it.port;
            r.drive_port = p;
            sel = in_claim[p] & ~out_claim[p];
            s = it.port_levels & sel;
            diff = (prev_raw[p] ^ s) & sel;
            prev_raw[p] = (prev_raw[p] & ~diff) | (s & diff);
            // only pins whose two latest samples agree take the new level
            flip = (lvl[p] ^ s) & sel & ~diff;
            lvl[p] = lvl[p] ^ flip;
            chg_flag[p] = chg_flag[p] | flip;
            sel = out_claim[p] & ~in_claim[p];
            r.drive_set = lvl[p] & sel;
            r.drive_reset = ~lvl[p] & sel;
            return r;
        end
        if (it.cmd > CMD_SAMPLE) return r;
        p = it.pin[5:4];
        m = 16'd1 << it.pin[3:0];
        r.drive_port = p;
        case (it.cmd)
            CMD_REGISTER: begin
                if (((in_claim[p] | out_claim[p]) & m) != 0) begin
                    r.status = 1'b1;
                end else begin
                    chg_flag[p] = chg_flag[p] & ~m;
                    if (it.is_output) begin
                        out_claim[p] = out_claim[p] | m;
                        r.pin_mode = MODE_OUTPUT_PP;
                        if (it.npn) begin
                            lvl[p] = lvl[p] | m;
                            r.drive_set = m;
                        end else begin
                            lvl[p] = lvl[p] & ~m;
                            r.drive_reset = m;
                        end
                    end else begin
                        in_claim[p] = in_claim[p] | m;
                        if (it.npn) begin
                            r.pin_mode = MODE_PULLUP;
                            prev_raw[p] = prev_raw[p] | m;
                            lvl[p] = lvl[p] | m;
                        end else begin
                            r.pin_mode = MODE_PULLDOWN;
                            prev_raw[p] = prev_raw[p] & ~m;
                            lvl[p] = lvl[p] & ~m;
                        end
                    end
                end
            end
            CMD_DELETE: begin
                out_claim[p] = out_claim[p] & ~m;
                in_claim[p] = in_claim[p] & ~m;
                r.pin_mode = MODE_FLOAT;
            end
            CMD_WRITE: begin
                chg_flag[p] = chg_flag[p] & ~m;
                if (it.value ^ it.npn) lvl[p] = lvl[p] | m;
                else lvl[p] = lvl[p] & ~m;
            end
            CMD_READ: begin
                chg_flag[p] = chg_flag[p] & ~m;
                r.read_value = ((lvl[p] & m) != 0) ^ it.npn;
            end
            default: begin
                r.changed = (chg_flag[p] & m) != 0;
            end
        endcase
        return r;
    endfunction

    task automatic cmp(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        item_t   it;
        result_t want;
        if (!aresetn) begin
            for (int i = 0; i < NP; i++) begin
                out_claim[i] = '0;
                in_claim[i]  = '0;
                prev_raw[i]  = '0;
                chg_flag[i]  = '0;
                lvl[i]       = '0;
            end
            due_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("result with no item outstanding");
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    cmp("status", 16'(want.status), 16'(m_status));
                    cmp("read_value", 16'(want.read_value), 16'(m_read_value));
                    cmp("changed", 16'(want.changed), 16'(m_changed));
                    cmp("pin_mode", 16'(want.pin_mode), 16'(m_pin_mode));
                    cmp("drive_port", 16'(want.drive_port), 16'(m_drive_port));
                    cmp("drive_set", want.drive_set, m_drive_set);
                    cmp("drive_reset", want.drive_reset, m_drive_reset);
                end
            end
            if (s_valid && s_ready) begin
                it.cmd = s_cmd;
                it.pin = s_pin;
                it.npn = s_npn;
                it.is_output = s_is_output;
                it.value = s_value;
                it.port = s_port;
                it.port_levels = s_port_levels;
                due_results.push_back(gpio_step(it));
            end
        end
        errors <= fails;
        pending <= due_results.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: clock, reset, stimulus and verdict for the gpio pin manager
module tb_top;
    import gpm_pkg::*;

    localparam logic [2:0] CMD_BAD_LO = 3'd6;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;
    localparam int ITEMS = 650;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic [2:0]  s_cmd = '0;
    logic [5:0]  s_pin = '0;
    logic        s_npn = 1'b0;
    logic        s_is_output = 1'b0;
    logic        s_value = 1'b0;
    logic [1:0]  s_port = '0;
    logic [15:0] s_port_levels = '0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_status;
    logic        m_read_value;
    logic        m_changed;
    logic [2:0]  m_pin_mode;
    logic [1:0]  m_drive_port;
    logic [15:0] m_drive_set;
    logic [15:0] m_drive_reset;
    int          errors;
    int          pending;

    int sent = 0;
    bit src_calm = 1'b0;
    bit snk_calm = 1'b0;

    gpio_pin_manager_debounce DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_pin(s_pin),
        .s_npn(s_npn), .s_is_output(s_is_output), .s_value(s_value),
        .s_port(s_port), .s_port_levels(s_port_levels),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_read_value(m_read_value), .m_changed(m_changed),
        .m_pin_mode(m_pin_mode), .m_drive_port(m_drive_port),
        .m_drive_set(m_drive_set), .m_drive_reset(m_drive_reset)
    );

    gpm_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_pin(s_pin),
        .s_npn(s_npn), .s_is_output(s_is_output), .s_value(s_value),
        .s_port(s_port), .s_port_levels(s_port_levels),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_read_value(m_read_value), .m_changed(m_changed),
        .m_pin_mode(m_pin_mode), .m_drive_port(m_drive_port),
        .m_drive_set(m_drive_set), .m_drive_reset(m_drive_reset),
        .errors(errors), .pending(pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.cmd = 3'($urandom_range(0, 7));
        it.pin = 6'($urandom);
        it.npn = 1'($urandom);
        it.is_output = 1'($urandom);
        it.value = 1'($urandom);
        it.port = 2'($urandom);
        it.port_levels = 16'($urandom);
        return it;
    endfunction

    task automatic send(item_t it);
        int gap;
        if ($urandom_range(0, 29) == 0) src_calm = !src_calm;
        gap = draw_wait(src_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= it.cmd;
        s_pin <= it.pin;
        s_npn <= it.npn;
        s_is_output <= it.is_output;
        s_value <= it.value;
        s_port <= it.port;
        s_port_levels <= it.port_levels;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (it.cmd <= CMD_SAMPLE) sent++;
    endtask

    task automatic pin_op(logic [2:0] cmd, logic [5:0] pin, logic npn, logic is_out,
                          logic val);
        item_t it;
        it = rand_item();
        it.cmd = cmd;
        it.pin = pin;
        it.npn = npn;
        it.is_output = is_out;
        it.value = val;
        send(it);
    endtask

    task automatic sample_op(logic [1:0] port, logic [15:0] levels);
        item_t it;
        it = rand_item();
        it.cmd = CMD_SAMPLE;
        it.port = port;
        it.port_levels = levels;
        send(it);
    endtask

    // claim an input, debounce a few samples, poll it, maybe touch it, maybe free it
    task automatic input_story();
        logic [5:0]  pin;
        logic        npn;
        logic [15:0] lv;
        int          k;
        pin = 6'($urandom);
        npn = 1'($urandom);
        k = $urandom_range(1, 4);
        pin_op(CMD_REGISTER, pin, npn, 1'b0, 1'($urandom));
        repeat (k) begin
            lv = 16'($urandom);
            sample_op(pin[5:4], lv);
            if ($urandom_range(0, 3) != 0) sample_op(pin[5:4], lv);
            pin_op(CMD_POLL, pin, npn, 1'($urandom), 1'($urandom));
        end
        case ($urandom_range(0, 2))
            0: pin_op(CMD_READ, pin, npn, 1'($urandom), 1'($urandom));
            1: pin_op(CMD_WRITE, pin, npn, 1'($urandom), 1'($urandom));
            default: ;
        endcase
        pin_op(CMD_POLL, pin, npn, 1'($urandom), 1'($urandom));
        if ($urandom_range(0, 4) < 3) pin_op(CMD_DELETE, pin, npn, 1'($urandom), 1'($urandom));
    endtask

    // claim an output, drive it through writes and port samples
    task automatic output_story();
        logic [5:0] pin;
        logic       npn;
        int         k;
        pin = 6'($urandom);
        npn = 1'($urandom);
        k = $urandom_range(1, 3);
        pin_op(CMD_REGISTER, pin, npn, 1'b1, 1'($urandom));
        repeat (k) begin
            pin_op(CMD_WRITE, pin, npn, 1'($urandom), 1'($urandom));
            sample_op(pin[5:4], 16'($urandom));
            pin_op(CMD_READ, pin, npn, 1'($urandom), 1'($urandom));
        end
        if ($urandom_range(0, 1) == 0) pin_op(CMD_DELETE, pin, npn, 1'($urandom), 1'($urandom));
    endtask

    initial begin
        int          n;
        logic [5:0]  pin;
        item_t       it;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: claims, busy pin, debounce, polarity, drive masks, odd commands
        pin_op(CMD_REGISTER, 6'd0, 1'b0, 1'b0, 1'b0);
        pin_op(CMD_REGISTER, 6'd0, 1'b1, 1'b1, 1'b1);
        pin_op(CMD_REGISTER, 6'd63, 1'b1, 1'b1, 1'b0);
        pin_op(CMD_REGISTER, 6'd17, 1'b0, 1'b1, 1'b0);
        pin_op(CMD_REGISTER, 6'd18, 1'b1, 1'b0, 1'b1);
        sample_op(2'd0, 16'hFFFF);
        sample_op(2'd0, 16'hFFFF);
        pin_op(CMD_POLL, 6'd0, 1'b0, 1'b0, 1'b0);
        pin_op(CMD_READ, 6'd0, 1'b0, 1'b0, 1'b0);
        pin_op(CMD_POLL, 6'd0, 1'b0, 1'b0, 1'b0);
        sample_op(2'd1, 16'h0000);
        sample_op(2'd1, 16'h0000);
        pin_op(CMD_POLL, 6'd18, 1'b1, 1'b0, 1'b0);
        pin_op(CMD_WRITE, 6'd63, 1'b1, 1'b0, 1'b0);
        sample_op(2'd3, 16'h0000);
        pin_op(CMD_WRITE, 6'd17, 1'b0, 1'b1, 1'b1);
        sample_op(2'd1, 16'hAAAA);
        pin_op(CMD_READ, 6'd63, 1'b1, 1'b0, 1'b0);
        pin_op(CMD_DELETE, 6'd0, 1'b0, 1'b0, 1'b0);
        pin_op(CMD_DELETE, 6'd63, 1'b1, 1'b1, 1'b1);
        pin_op(CMD_WRITE, 6'd40, 1'b1, 1'b0, 1'b1);
        pin_op(CMD_READ, 6'd40, 1'b0, 1'b0, 1'b0);
        pin_op(CMD_BAD_LO, 6'd63, 1'b1, 1'b1, 1'b1);
        pin_op(CMD_BAD_HI, 6'd0, 1'b0, 1'b0, 1'b0);
        sample_op(2'd2, 16'h5555);

        while (sent < ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: input_story();
                4, 5, 6: output_story();
                7: begin
                    pin = 6'($urandom);
                    pin_op(CMD_REGISTER, pin, 1'($urandom), 1'($urandom), 1'($urandom));
                    pin_op(CMD_REGISTER, pin, 1'($urandom), 1'($urandom), 1'($urandom));
                    pin_op(CMD_DELETE, pin, 1'($urandom), 1'($urandom), 1'($urandom));
                end
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        it = rand_item();
                        send(it);
                    end
                end
            endcase
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        for (n = 0; n < 5000 && pending != 0; n++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 29) == 0) snk_calm = !snk_calm;
            stall = draw_wait(snk_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
